[sv/dcp_pkg.sv]
// Package for the digest challenge parser: parser state and result types,
// phase and code constants, name tables and byte helper functions.
// No dependencies; every module of the parser imports it.
package dcp_pkg;

    // Number of leading bytes (the scheme word) that are dropped.
    localparam logic [2:0] PREFIX_LEN = 3'd6;

    // Saturation value of every length counter.
    localparam logic [3:0] LEN_SAT = 4'd15;

    // Width of a packed candidate string, left aligned.
    localparam int STR_BYTES = 12;
    localparam int STR_W     = 8 * STR_BYTES;

    // Parser phase, one-hot.
    typedef enum logic [4:0] {
        PH_SEP  = 5'b00001,
        PH_NAME = 5'b00010,
        PH_EQ   = 5'b00100,
        PH_QVAL = 5'b01000,
        PH_UVAL = 5'b10000
    } phase_t;

    // Field codes of a recognised name.
    localparam logic [2:0] FLD_NONE   = 3'd0;
    localparam logic [2:0] FLD_REALM  = 3'd1;
    localparam logic [2:0] FLD_DOMAIN = 3'd2;
    localparam logic [2:0] FLD_NONCE  = 3'd3;
    localparam logic [2:0] FLD_OPAQUE = 3'd4;
    localparam logic [2:0] FLD_STALE  = 3'd5;
    localparam logic [2:0] FLD_ALGO   = 3'd6;
    localparam logic [2:0] FLD_QOP    = 3'd7;

    // Algorithm kinds.
    localparam logic [2:0] ALG_UNKNOWN   = 3'd0;
    localparam logic [2:0] ALG_MD5       = 3'd1;

    // Error codes.
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_NO_VALUE = 2'd1;
    localparam logic [1:0] ERR_QUOTE    = 2'd2;

    // Characters with a meaning to the parser.
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_EQUAL = 8'h3D;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    // Parameter names, in field code order starting at realm.
    localparam logic [STR_W-1:0] NAME_STR [7] = '{
        {"realm",     56'h0},
        {"domain",    48'h0},
        {"nonce",     56'h0},
        {"opaque",    48'h0},
        {"stale",     56'h0},
        {"algorithm", 24'h0},
        {"qop",       72'h0}
    };
    localparam logic [3:0] NAME_LEN [7] = '{4'd5, 4'd6, 4'd5, 4'd6, 4'd5, 4'd9, 4'd3};

    // Algorithm names, in kind order starting at MD5.
    localparam logic [STR_W-1:0] ALGO_STR [4] = '{
        {"md5",          72'h0},
        {"md5-sess",     32'h0},
        {"sha-256",      40'h0},
        {"sha-256-sess"}
    };
    localparam logic [3:0] ALGO_LEN [4] = '{4'd3, 4'd8, 4'd7, 4'd12};

    // Quality of protection tokens.
    localparam logic [STR_W-1:0] TOK_STR [2] = '{
        {"auth",     64'h0},
        {"auth-int", 32'h0}
    };
    localparam logic [3:0] TOK_LEN [2] = '{4'd4, 4'd8};

    localparam logic [STR_W-1:0] TRUE_STR = {"true", 64'h0};
    localparam logic [2:0] TRUE_DONE = 3'd4;
    localparam logic [2:0] TRUE_FAIL = 3'd5;

    // Parser state carried from one byte to the next.
    typedef struct packed {
        logic [2:0] prefix_count;
        phase_t     phase;
        logic [3:0] name_length;
        logic [6:0] name_match;
        logic [2:0] current_field;
        logic [3:0] value_length;
        logic [3:0] algo_match;
        logic [3:0] token_length;
        logic [1:0] token_match;
        logic [2:0] true_progress;
        logic       stale_state;
        logic [3:0] algo_state;   // bit 3 specified, bits 2:0 kind
        logic [1:0] qop_state;
        logic [1:0] error_state;
        logic [1:0] qop_pending;
    } state_t;

    localparam state_t STATE_RESET = '{
        prefix_count:  3'd0,
        phase:         PH_SEP,
        name_length:   4'd0,
        name_match:    7'h7F,
        current_field: FLD_NONE,
        value_length:  4'd0,
        algo_match:    4'hF,
        token_length:  4'd0,
        token_match:   2'b11,
        true_progress: 3'd0,
        stale_state:   1'b0,
        algo_state:    {1'b0, ALG_MD5},
        qop_state:     2'b00,
        error_state:   ERR_NONE,
        qop_pending:   2'b00
    };

    // One result word.
    typedef struct packed {
        logic [7:0] value_byte;
        logic [2:0] value_field;
        logic       value_first;
        logic       done_res;
        logic [1:0] parse_error;
        logic       stale_flag;
        logic       algo_given;
        logic [2:0] algo_kind;
        logic       qop_has_auth;
        logic       qop_has_auth_int;
    } res_t;

    // ASCII lower case.
    function automatic logic [7:0] lower_ch(input logic [7:0] c);
        return (c >= CH_UPPER_A && c <= CH_UPPER_Z) ? c + CASE_OFFSET : c;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
    endfunction

    // Byte at position i of a left-aligned candidate string.
    function automatic logic [7:0] chr_at(input logic [STR_W-1:0] s, input logic [3:0] i);
        logic [STR_W-1:0] t;
        t = s << {i, 3'b000};
        return t[STR_W-1 -: 8];
    endfunction

endpackage

[sv/dcp_step.sv]
// Combinational next-state and result logic for one challenge byte.
// Depends on dcp_pkg for the state and result types and the name tables.
module dcp_step
    import dcp_pkg::*;
(
    input  state_t     cur,
    input  logic [7:0] char_in,
    input  logic       last_char,
    output state_t     nxt,
    output res_t       res
);

    // One byte of a parameter name narrows the name candidates.
    function automatic state_t name_byte(input state_t s, input logic [7:0] lc);
        state_t r;
        r = s;
        for (int k = 0; k < 7; k++) begin
            if (s.name_length >= NAME_LEN[k] || lc != chr_at(NAME_STR[k], s.name_length))
            begin
                r.name_match[k] = 1'b0;
            end
        end
        if (s.name_length != LEN_SAT) r.name_length = s.name_length + 4'd1;
        return r;
    endfunction

    // Start of a value: pick the first complete name and clear the matchers.
    function automatic state_t value_begin(input state_t s);
        state_t r;
        r = s;
        r.current_field = FLD_NONE;
        for (int k = 6; k >= 0; k--) begin
            if (s.name_match[k] && s.name_length == NAME_LEN[k]) begin
                r.current_field = 3'(k + 1);
            end
        end
        r.value_length  = 4'd0;
        r.algo_match    = 4'hF;
        r.token_length  = 4'd0;
        r.token_match   = 2'b11;
        r.true_progress = 3'd0;
        r.qop_pending   = 2'b00;
        return r;
    endfunction

    // Close the qop token in progress.
    function automatic state_t token_end(input state_t s);
        state_t r;
        r = s;
        if (s.token_length == TOK_LEN[0] && s.token_match[0]) r.qop_pending[0] = 1'b1;
        if (s.token_length == TOK_LEN[1] && s.token_match[1]) r.qop_pending[1] = 1'b1;
        r.token_length = 4'd0;
        r.token_match  = 2'b11;
        return r;
    endfunction

    // One byte of a value: stream it if captured and advance every matcher.
    function automatic state_t value_byte(input state_t s, input logic [7:0] c,
                                          inout res_t o);
        state_t     r;
        logic [7:0] lc;
        r  = s;
        lc = lower_ch(c);
        if (s.current_field >= FLD_REALM && s.current_field <= FLD_OPAQUE) begin
            o.value_byte  = c;
            o.value_field = s.current_field;
            o.value_first = (s.value_length == 4'd0);
        end
        if (s.true_progress < TRUE_DONE) begin
            if (lc == chr_at(TRUE_STR, {1'b0, s.true_progress}))
                r.true_progress = s.true_progress + 3'd1;
            else
                r.true_progress = TRUE_FAIL;
        end
        for (int k = 0; k < 4; k++) begin
            if (s.value_length >= ALGO_LEN[k] || lc != chr_at(ALGO_STR[k], s.value_length))
            begin
                r.algo_match[k] = 1'b0;
            end
        end
        if (is_space(c) || c == CH_COMMA) begin
            r = token_end(r);
        end else begin
            for (int k = 0; k < 2; k++) begin
                if (s.token_length >= TOK_LEN[k] ||
                    lc != chr_at(TOK_STR[k], s.token_length))
                begin
                    r.token_match[k] = 1'b0;
                end
            end
            if (s.token_length != LEN_SAT) r.token_length = s.token_length + 4'd1;
        end
        if (s.value_length != LEN_SAT) r.value_length = s.value_length + 4'd1;
        return r;
    endfunction

    // End of a value: report an empty captured value or commit a summary field.
    function automatic state_t value_end(input state_t s, inout res_t o);
        state_t     r;
        logic [2:0] kind;
        r    = token_end(s);
        kind = ALG_UNKNOWN;
        if (r.current_field >= FLD_REALM && r.current_field <= FLD_OPAQUE &&
            r.value_length == 4'd0)
        begin
            o.value_byte  = 8'h00;
            o.value_field = r.current_field;
            o.value_first = 1'b1;
        end else if (r.current_field == FLD_STALE) begin
            r.stale_state = (r.true_progress == TRUE_DONE);
        end else if (r.current_field == FLD_ALGO) begin
            for (int k = 0; k < 4; k++) begin
                if (r.algo_match[k] && r.value_length == ALGO_LEN[k]) kind = 3'(k + 1);
            end
            r.algo_state = {1'b1, kind};
        end else if (r.current_field == FLD_QOP) begin
            r.qop_state = r.qop_state | r.qop_pending;
        end
        return r;
    endfunction

    // Per-byte parse step, followed by the end-of-challenge report.
    always_comb
    begin
        state_t     s;
        res_t       o;
        logic       sep;
        logic [7:0] lc;
        s   = cur;
        o   = '0;
        sep = is_space(char_in) || char_in == CH_COMMA;
        lc  = lower_ch(char_in);

        if (cur.prefix_count < PREFIX_LEN) begin
            s.prefix_count = cur.prefix_count + 3'd1;
        end else begin
            unique case (cur.phase)
                PH_SEP:
                begin
                    if (!sep) begin
                        s.name_length = 4'd0;
                        s.name_match  = 7'h7F;
                        s.phase       = PH_NAME;
                        s             = name_byte(s, lc);
                    end
                end
                PH_NAME:
                begin
                    if (is_space(char_in) || char_in == CH_EQUAL) s.phase = PH_EQ;
                    else s = name_byte(s, lc);
                end
                PH_EQ:
                begin
                    if (!(is_space(char_in) || char_in == CH_EQUAL)) begin
                        s = value_begin(s);
                        if (char_in == CH_QUOTE) begin
                            s.phase = PH_QVAL;
                        end else if (char_in == CH_COMMA) begin
                            s       = value_end(s, o);
                            s.phase = PH_SEP;
                        end else begin
                            s.phase = PH_UVAL;
                            s       = value_byte(s, char_in, o);
                        end
                    end
                end
                PH_QVAL:
                begin
                    if (char_in == CH_QUOTE) begin
                        s       = value_end(s, o);
                        s.phase = PH_SEP;
                    end else begin
                        s = value_byte(s, char_in, o);
                    end
                end
                default:
                begin
                    if (sep) begin
                        s       = value_end(s, o);
                        s.phase = PH_SEP;
                    end else begin
                        s = value_byte(s, char_in, o);
                    end
                end
            endcase
        end

        // Final byte: close what is open, report the summary and start afresh.
        if (last_char) begin
            if (s.prefix_count >= PREFIX_LEN) begin
                if (s.phase == PH_NAME || s.phase == PH_EQ) s.error_state = ERR_NO_VALUE;
                else if (s.phase == PH_QVAL) s.error_state = ERR_QUOTE;
                else if (s.phase == PH_UVAL) s = value_end(s, o);
            end
            o.done_res         = 1'b1;
            o.parse_error      = s.error_state;
            o.stale_flag       = s.stale_state;
            o.algo_given       = s.algo_state[3];
            o.algo_kind        = s.algo_state[2:0];
            o.qop_has_auth     = s.qop_state[0];
            o.qop_has_auth_int = s.qop_state[1];
            s                  = STATE_RESET;
        end

        nxt = s;
        res = o;
    end

endmodule

[sv/digest_challenge_parser.sv]
// Top level of the digest challenge parser: input word register, parser
// state register and result register around the dcp_step logic.
// Depends on dcp_pkg and dcp_step.
//
//  Channel  Handshake                Payload
//  -------  -----------------------  --------------------------------------------
//  input    char_valid / char_stall  char_in, last_char
//  result   res_valid / res_stall    value_byte, value_field, value_first,
//                                    done_res, parse_error, stale_flag,
//                                    algo_given, algo_kind, qop_has_auth,
//                                    qop_has_auth_int
//
// One word is taken every cycle while char_stall is low; each gives exactly
// one result word, which is registered twice: in the input register, then in
// the result register.
// The parse step between the two registers sets the rate: it updates the small
// name, algorithm and token match vectors and counters for one byte per cycle.
// Reset clears the parser state, so the first word starts a new challenge.
// A stalled result holds its register; the input register fills behind it and
// then char_stall is raised until the result is taken.
module digest_challenge_parser
    import dcp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       char_valid,
    output logic       char_stall,
    input  logic [7:0] char_in,
    input  logic       last_char,
    output logic       res_valid,
    input  logic       res_stall,
    output logic [7:0] value_byte,
    output logic [2:0] value_field,
    output logic       value_first,
    output logic       done_res,
    output logic [1:0] parse_error,
    output logic       stale_flag,
    output logic       algo_given,
    output logic [2:0] algo_kind,
    output logic       qop_has_auth,
    output logic       qop_has_auth_int
);

    logic       hold_valid_reg;
    logic [7:0] hold_char_reg;
    logic       hold_last_reg;
    state_t     state_reg;
    state_t     state_next;
    res_t       res_next;
    res_t       res_reg;
    logic       res_valid_reg;
    logic       advance;

    // A held word moves on when the result register is empty or being emptied.
    assign advance    = hold_valid_reg && (!res_valid_reg || !res_stall);
    assign char_stall = hold_valid_reg && !advance;

    // Input word register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            hold_valid_reg <= 1'b0;
        end else if (!char_stall) begin
            hold_valid_reg <= char_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!char_stall && char_valid) begin
            hold_char_reg <= char_in;
            hold_last_reg <= last_char;
        end
    end

    // Parse step for the held word.
    dcp_step u_step (
        .cur       (state_reg),
        .char_in   (hold_char_reg),
        .last_char (hold_last_reg),
        .nxt       (state_next),
        .res       (res_next)
    );

    // Parser state register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= STATE_RESET;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            res_valid_reg <= 1'b0;
        end else if (advance) begin
            res_valid_reg <= 1'b1;
        end else if (!res_stall) begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance) begin
            res_reg <= res_next;
        end
    end

    // Result ports.
    assign res_valid        = res_valid_reg;
    assign value_byte       = res_reg.value_byte;
    assign value_field      = res_reg.value_field;
    assign value_first      = res_reg.value_first;
    assign done_res         = res_reg.done_res;
    assign parse_error      = res_reg.parse_error;
    assign stale_flag       = res_reg.stale_flag;
    assign algo_given       = res_reg.algo_given;
    assign algo_kind        = res_reg.algo_kind;
    assign qop_has_auth     = res_reg.qop_has_auth;
    assign qop_has_auth_int = res_reg.qop_has_auth_int;

endmodule

[sim/tb_top.sv]
// Self-checking testbench for digest_challenge_parser: drives challenge bytes
// with random bursts and stalls, predicts every result word and compares it.
// Depends on dcp_pkg and the digest_challenge_parser RTL.
module tb_top
    import dcp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HEADER_BYTES   = 1900;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 150;
    localparam int DRAIN_CYCLES   = 8;
    localparam int REPORT_LIMIT   = 10;

    typedef struct {
        logic [7:0] ch;
        logic       fin;
    } hdr_word_t;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_EVERY3
    } stall_mode_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       char_valid = 1'b0;
    logic       char_stall;
    logic [7:0] char_in = 8'h00;
    logic       last_char = 1'b0;
    logic       res_valid;
    logic       res_stall = 1'b0;
    logic [7:0] value_byte;
    logic [2:0] value_field;
    logic       value_first;
    logic       done_res;
    logic [1:0] parse_error;
    logic       stale_flag;
    logic       algo_given;
    logic [2:0] algo_kind;
    logic       qop_has_auth;
    logic       qop_has_auth_int;

    digest_challenge_parser u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .char_valid       (char_valid),
        .char_stall       (char_stall),
        .char_in          (char_in),
        .last_char        (last_char),
        .res_valid        (res_valid),
        .res_stall        (res_stall),
        .value_byte       (value_byte),
        .value_field      (value_field),
        .value_first      (value_first),
        .done_res         (done_res),
        .parse_error      (parse_error),
        .stale_flag       (stale_flag),
        .algo_given       (algo_given),
        .algo_kind        (algo_kind),
        .qop_has_auth     (qop_has_auth),
        .qop_has_auth_int (qop_has_auth_int)
    );

    always #6 clk = ~clk;

    // Words still to be sent, and result words owed by the parser.
    hdr_word_t header_bytes [$];
    res_t      due_results [$];
    logic [7:0] draft [$];

    int fail_count = 0;

    // Words recognised by the parser, all in lower case.
    string key_words [7] = '{"realm", "domain", "nonce", "opaque", "stale", "algorithm", "qop"};
    string algo_words [4] = '{"md5", "md5-sess", "sha-256", "sha-256-sess"};
    string qop_words [2] = '{"auth", "auth-int"};
    string true_word = "true";

    // Material for the generated challenges.
    string stale_vals [8] = '{"true", "TRUE", "tRuE", "truest", "false", "tru", "FALSE",
                              "xtrue"};
    string algo_vals [10] = '{"MD5", "md5-sess", "SHA-256", "sha-256-sess", "md5x",
                              "sha-256-ses", "sha-512", "MD5-SESS", "md",
                              "sha-256-sessions"};
    string qop_toks [6] = '{"auth", "auth-int", "auth-intx", "aut", "AUTH-INT", "auth-conf"};
    string qop_joins [4] = '{", ", ",", " ", " ,\t"};
    string odd_names [3] = '{"realms", "qo", "algorithmalgorithm"};
    logic [7:0] sep_chars [5] = '{CH_SPACE, CH_TAB, CH_CR, CH_LF, CH_COMMA};
    logic [7:0] eq_chars [3] = '{CH_EQUAL, CH_SPACE, CH_TAB};

    // ------------------------------------------------------------------
    // Parser prediction state for the challenge in progress.
    // ------------------------------------------------------------------
    logic [2:0] hdr_skip;
    phase_t     ph;
    logic [3:0] key_len;
    logic [6:0] key_hits;
    logic [2:0] fld;
    logic [3:0] val_len;
    logic [3:0] alg_hits;
    logic [3:0] tok_len;
    logic [1:0] tok_hits;
    logic [2:0] true_pos;
    logic       stale_seen;
    logic [3:0] alg_code;
    logic [1:0] qop_seen;
    logic [1:0] err_code;
    logic [1:0] qop_open;

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        if (c >= "A" && c <= "Z")
        begin
            return c + 8'd32;
        end
        return c;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
    endfunction

    task automatic clear_challenge();
        hdr_skip   = 3'd0;
        ph         = PH_SEP;
        key_len    = 4'd0;
        key_hits   = 7'h7F;
        fld        = FLD_NONE;
        val_len    = 4'd0;
        alg_hits   = 4'hF;
        tok_len    = 4'd0;
        tok_hits   = 2'b11;
        true_pos   = 3'd0;
        stale_seen = 1'b0;
        alg_code   = {1'b0, ALG_MD5};
        qop_seen   = 2'b00;
        err_code   = ERR_NONE;
        qop_open   = 2'b00;
    endtask

    // One byte of a parameter name narrows the set of possible names.
    task automatic take_key_char(input logic [7:0] c);
        logic [7:0] lc;
        int k;
        lc = fold_case(c);
        for (k = 0; k < 7; k++)
        begin
            if (int'(key_len) >= key_words[k].len() || lc != key_words[k][key_len])
            begin
                key_hits[k] = 1'b0;
            end
        end
        if (key_len != LEN_SAT)
        begin
            key_len++;
        end
    endtask

    // The name is complete: decide which field the value belongs to.
    task automatic open_value();
        int k;
        fld = FLD_NONE;
        for (k = 6; k >= 0; k--)
        begin
            if (key_hits[k] && int'(key_len) == key_words[k].len())
            begin
                fld = 3'(k + 1);
            end
        end
        val_len  = 4'd0;
        alg_hits = 4'hF;
        tok_len  = 4'd0;
        tok_hits = 2'b11;
        true_pos = 3'd0;
        qop_open = 2'b00;
    endtask

    task automatic close_token();
        if (int'(tok_len) == qop_words[0].len() && tok_hits[0])
        begin
            qop_open[0] = 1'b1;
        end
        if (int'(tok_len) == qop_words[1].len() && tok_hits[1])
        begin
            qop_open[1] = 1'b1;
        end
        tok_len  = 4'd0;
        tok_hits = 2'b11;
    endtask

    // One value byte: stream it if captured, and advance every matcher.
    task automatic take_value_char(input logic [7:0] c, inout res_t r);
        logic [7:0] lc;
        int k;
        lc = fold_case(c);
        if (fld >= FLD_REALM && fld <= FLD_OPAQUE)
        begin
            r.value_byte  = c;
            r.value_field = fld;
            r.value_first = (val_len == 4'd0);
        end
        if (true_pos < TRUE_DONE)
        begin
            true_pos = (lc == true_word[true_pos]) ? true_pos + 3'd1 : TRUE_FAIL;
        end
        for (k = 0; k < 4; k++)
        begin
            if (int'(val_len) >= algo_words[k].len() || lc != algo_words[k][val_len])
            begin
                alg_hits[k] = 1'b0;
            end
        end
        if (is_blank(c) || c == CH_COMMA)
        begin
            close_token();
        end
        else
        begin
            for (k = 0; k < 2; k++)
            begin
                if (int'(tok_len) >= qop_words[k].len() || lc != qop_words[k][tok_len])
                begin
                    tok_hits[k] = 1'b0;
                end
            end
            if (tok_len != LEN_SAT)
            begin
                tok_len++;
            end
        end
        if (val_len != LEN_SAT)
        begin
            val_len++;
        end
    endtask

    // The value is complete: report an empty captured value, or update
    // stale, algorithm or qop.
    task automatic close_value(inout res_t r);
        logic [2:0] kind;
        int k;
        close_token();
        if (fld >= FLD_REALM && fld <= FLD_OPAQUE && val_len == 4'd0)
        begin
            r.value_byte  = 8'h00;
            r.value_field = fld;
            r.value_first = 1'b1;
        end
        else if (fld == FLD_STALE)
        begin
            stale_seen = (true_pos == TRUE_DONE);
        end
        else if (fld == FLD_ALGO)
        begin
            kind = ALG_UNKNOWN;
            for (k = 0; k < 4; k++)
            begin
                if (alg_hits[k] && int'(val_len) == algo_words[k].len())
                begin
                    kind = 3'(k + 1);
                end
            end
            alg_code = {1'b1, kind};
        end
        else if (fld == FLD_QOP)
        begin
            qop_seen = qop_seen | qop_open;
        end
    endtask

    // Expected result word for one accepted header byte.
    task automatic parse_header_byte(input logic [7:0] c, input logic fin, output res_t r);
        r = '0;
        if (hdr_skip < PREFIX_LEN)
        begin
            hdr_skip++;
        end
        else
        begin
            case (ph)
                PH_SEP:
                begin
                    if (!(is_blank(c) || c == CH_COMMA))
                    begin
                        key_len  = 4'd0;
                        key_hits = 7'h7F;
                        ph       = PH_NAME;
                        take_key_char(c);
                    end
                end
                PH_NAME:
                begin
                    if (is_blank(c) || c == CH_EQUAL)
                    begin
                        ph = PH_EQ;
                    end
                    else
                    begin
                        take_key_char(c);
                    end
                end
                PH_EQ:
                begin
                    if (!(is_blank(c) || c == CH_EQUAL))
                    begin
                        open_value();
                        if (c == CH_QUOTE)
                        begin
                            ph = PH_QVAL;
                        end
                        else if (c == CH_COMMA)
                        begin
                            close_value(r);
                            ph = PH_SEP;
                        end
                        else
                        begin
                            ph = PH_UVAL;
                            take_value_char(c, r);
                        end
                    end
                end
                PH_QVAL:
                begin
                    if (c == CH_QUOTE)
                    begin
                        close_value(r);
                        ph = PH_SEP;
                    end
                    else
                    begin
                        take_value_char(c, r);
                    end
                end
                default:
                begin
                    if (is_blank(c) || c == CH_COMMA)
                    begin
                        close_value(r);
                        ph = PH_SEP;
                    end
                    else
                    begin
                        take_value_char(c, r);
                    end
                end
            endcase
        end
        // Final byte: settle the error, then report and start afresh.
        if (fin)
        begin
            if (hdr_skip >= PREFIX_LEN)
            begin
                if (ph == PH_NAME || ph == PH_EQ)
                begin
                    err_code = ERR_NO_VALUE;
                end
                else if (ph == PH_QVAL)
                begin
                    err_code = ERR_QUOTE;
                end
                else if (ph == PH_UVAL)
                begin
                    close_value(r);
                end
            end
            r.done_res         = 1'b1;
            r.parse_error      = err_code;
            r.stale_flag       = stale_seen;
            r.algo_given       = alg_code[3];
            r.algo_kind        = alg_code[2:0];
            r.qop_has_auth     = qop_seen[0];
            r.qop_has_auth_int = qop_seen[1];
            clear_challenge();
        end
    endtask

    // ------------------------------------------------------------------
    // Challenge generation.
    // ------------------------------------------------------------------
    function automatic logic [7:0] any_case(input logic [7:0] c);
        if (c >= "a" && c <= "z" && $urandom_range(0, 1) == 1)
        begin
            return c - 8'd32;
        end
        if (c >= "A" && c <= "Z" && $urandom_range(0, 1) == 1)
        begin
            return c + 8'd32;
        end
        return c;
    endfunction

    // A byte of free value text; quotes never appear, commas only when quoted.
    function automatic logic [7:0] text_char(input bit quoted);
        logic [7:0] c;
        case ($urandom_range(0, 15))
            0:       c = 8'h00;
            1:       c = 8'($urandom_range(128, 255));
            2:       c = quoted ? CH_SPACE : "x";
            default: c = 8'($urandom_range(33, 126));
        endcase
        if (c == CH_QUOTE)
        begin
            c = "q";
        end
        if (!quoted && c == CH_COMMA)
        begin
            c = "c";
        end
        return c;
    endfunction

    task automatic put_word(input string s, input bit mix);
        int i;
        for (i = 0; i < s.len(); i++)
        begin
            draft.push_back(mix ? any_case(s[i]) : s[i]);
        end
    endtask

    task automatic put_separators(input int lo, input int hi);
        repeat ($urandom_range(lo, hi))
        begin
            draft.push_back(sep_chars[$urandom_range(0, 4)]);
        end
    endtask

    // One name=value pair; open_end says an unquoted value still needs ending.
    task automatic put_pair(output bit open_end);
        int pick;
        int style;
        bit quoted;
        logic [2:0] key_fld;
        open_end = 1'b0;
        key_fld  = FLD_NONE;
        pick     = $urandom_range(0, 13);
        if (pick < 7)
        begin
            put_word(key_words[pick], 1'b1);
            key_fld = 3'(pick + 1);
        end
        else if (pick < 10)
        begin
            put_word(key_words[pick - 3], 1'b1);
            key_fld = 3'(pick - 2);
        end
        else if (pick < 13)
        begin
            put_word(odd_names[pick - 10], 1'b1);
        end
        else
        begin
            repeat ($urandom_range(1, 6))
            begin
                draft.push_back(any_case(8'h61 + 8'($urandom_range(0, 25))));
            end
        end
        repeat ($urandom_range(1, 3))
        begin
            draft.push_back(eq_chars[$urandom_range(0, 2)]);
        end
        style = $urandom_range(0, 19);
        if (style == 18)
        begin
            draft.push_back(CH_COMMA);
        end
        else if (style == 19)
        begin
            draft.push_back(CH_QUOTE);
            draft.push_back(CH_QUOTE);
        end
        else
        begin
            quoted = (style < 10);
            if (quoted)
            begin
                draft.push_back(CH_QUOTE);
            end
            if (key_fld == FLD_STALE)
            begin
                put_word(stale_vals[$urandom_range(0, 7)], 1'b1);
            end
            else if (key_fld == FLD_ALGO)
            begin
                put_word(algo_vals[$urandom_range(0, 9)], 1'b1);
            end
            else if (key_fld == FLD_QOP)
            begin
                put_word(qop_toks[$urandom_range(0, 5)], 1'b0);
                if (quoted)
                begin
                    repeat ($urandom_range(0, 2))
                    begin
                        put_word(qop_joins[$urandom_range(0, 3)], 1'b0);
                        put_word(qop_toks[$urandom_range(0, 5)], 1'b0);
                    end
                end
            end
            else
            begin
                repeat ($urandom_range(1, 20))
                begin
                    draft.push_back(text_char(quoted));
                end
            end
            if (quoted)
            begin
                draft.push_back(CH_QUOTE);
            end
            else
            begin
                open_end = 1'b1;
            end
        end
    endtask

    // Move the draft challenge onto the send queue, marking its last byte.
    task automatic ship_draft();
        hdr_word_t w;
        int i;
        for (i = 0; i < draft.size(); i++)
        begin
            w.ch  = draft[i];
            w.fin = (i == draft.size() - 1);
            header_bytes.push_back(w);
        end
        draft.delete();
    endtask

    task automatic ship_text(input string s);
        put_word(s, 1'b0);
        ship_draft();
    endtask

    // Mostly well-formed challenges with random content, some cut short,
    // plus short challenges and plain noise.
    task automatic build_challenge();
        int kind;
        int pairs;
        int keep;
        int i;
        bit open_end;
        kind = $urandom_range(0, 99);
        if (kind < 6)
        begin
            repeat ($urandom_range(1, 6))
            begin
                draft.push_back(8'($urandom_range(0, 255)));
            end
        end
        else if (kind < 12)
        begin
            repeat ($urandom_range(7, 30))
            begin
                draft.push_back(8'($urandom_range(0, 255)));
            end
        end
        else
        begin
            if ($urandom_range(0, 4) != 0)
            begin
                put_word("Digest", 1'b1);
            end
            else
            begin
                repeat (6)
                begin
                    draft.push_back(8'($urandom_range(1, 255)));
                end
            end
            put_separators(0, 2);
            open_end = 1'b0;
            pairs = $urandom_range(1, 5);
            for (i = 0; i < pairs; i++)
            begin
                if (i > 0)
                begin
                    put_separators(open_end ? 1 : 0, 3);
                end
                put_pair(open_end);
            end
            if ($urandom_range(0, 2) == 0)
            begin
                put_separators(1, 2);
            end
            if ($urandom_range(0, 6) == 0)
            begin
                keep = $urandom_range(7, draft.size());
                while (draft.size() > keep)
                begin
                    draft.delete(draft.size() - 1);
                end
            end
        end
        ship_draft();
    endtask

    // ------------------------------------------------------------------
    // Sender: bursts of words with random gaps; predicts each accepted word.
    // ------------------------------------------------------------------
    int        burst_left = 0;
    int        gap_left = 0;
    res_t      next_due;
    hdr_word_t next_word;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_valid <= 1'b0;
            char_in    <= 8'h00;
            last_char  <= 1'b0;
        end
        else
        begin
            if (char_valid && !char_stall)
            begin
                parse_header_byte(char_in, last_char, next_due);
                due_results.push_back(next_due);
            end
            if (!char_valid || !char_stall)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    char_valid <= 1'b0;
                end
                else if (header_bytes.size() != 0)
                begin
                    next_word = header_bytes.pop_front();
                    char_in    <= next_word.ch;
                    last_char  <= next_word.fin;
                    char_valid <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 30);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                    else
                    begin
                        burst_left--;
                    end
                end
                else
                begin
                    char_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: stall pattern in phases, with a long hold-off now and then
    // so that the parser fills and stalls its input.
    // ------------------------------------------------------------------
    stall_mode_t stall_mode = STALL_NONE;
    int          mode_left = 0;
    int          hold_left = 0;
    int          hold_at = 300;
    int          taken = 0;
    int          tick = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_stall <= 1'b0;
        end
        else
        begin
            tick++;
            if (res_valid && !res_stall)
            begin
                taken++;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                res_stall <= 1'b1;
            end
            else if (taken >= hold_at)
            begin
                hold_left = HOLD_CYCLES;
                hold_at   = hold_at + 900;
                res_stall <= 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    stall_mode = stall_mode_t'($urandom_range(0, 3));
                    mode_left  = $urandom_range(40, 200);
                end
                else
                begin
                    mode_left--;
                end
                case (stall_mode)
                    STALL_NONE:   res_stall <= 1'b0;
                    STALL_LIGHT:  res_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HEAVY:  res_stall <= ($urandom_range(0, 9) < 7);
                    default:      res_stall <= (tick % 3 == 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checker.
    // ------------------------------------------------------------------
    function automatic string describe(input res_t x);
        return $sformatf("byte=%h field=%0d first=%b done=%b err=%0d stale=%b alg=%b/%0d qop=%b%b",
                         x.value_byte, x.value_field, x.value_first, x.done_res,
                         x.parse_error, x.stale_flag, x.algo_given, x.algo_kind,
                         x.qop_has_auth, x.qop_has_auth_int);
    endfunction

    res_t got_word;
    res_t due_word;

    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            got_word = {value_byte, value_field, value_first, done_res, parse_error,
                        stale_flag, algo_given, algo_kind, qop_has_auth, qop_has_auth_int};
            if (due_results.size() == 0)
            begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                begin
                    $display("%t: result word with none expected: %s", $realtime,
                             describe(got_word));
                end
            end
            else
            begin
                due_word = due_results.pop_front();
                if (got_word !== due_word)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                    begin
                        $display("%t: result mismatch", $realtime);
                        $display("    expected %s", describe(due_word));
                        $display("    actual   %s", describe(got_word));
                    end
                end
            end
        end
    end

    // Watchdog: too long without any word moving on either side.
    int idle_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((char_valid && !char_stall) || (res_valid && !res_stall))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("Simulation FAILED");
                    $finish;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus, reset and end of run.
    // ------------------------------------------------------------------
    initial
    begin
        clear_challenge();

        // Directed challenges: short, full, each error and the byte extremes.
        ship_text("Dig");
        ship_text({"Digest realm=\"a b\",nonce=xyz, opaque=\"\", domain=, stale=TRUE, ",
                   "algorithm=SHA-256-sess, qop=\"auth,auth-int\""});
        ship_text("Digest algorithm=MD5-sess qop=auth stale=false realm=");
        ship_text("Digest nonce=\"abc");
        ship_text("Digest realm");
        ship_text("Digest algorithm=foo,qop=\"auth-int auth\",stale=\"true\"");
        put_word("Digest opaque=", 1'b0);
        draft.push_back(8'hFF);
        draft.push_back(8'h00);
        draft.push_back("x");
        ship_draft();

        // Random challenges.
        while (header_bytes.size() < HEADER_BYTES)
        begin
            build_challenge();
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (header_bytes.size() != 0 || char_valid)
        begin
            @(posedge clk);
        end
        while (due_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
